FILE: design/ils_pkg.sv
// Shared types and constants for the indexed shift list.
`default_nettype none

package ils_pkg;

    // Default number of cells and the capacity after reset.
    localparam int DEPTH_DEFAULT = 16;
    localparam logic [4:0] CAP_RESET = 5'd16;

    // A dump emits at most this many words.
    localparam int RESULT_LIMIT = 16;

    // Width of the index fields broadcast to the cells (covers DEPTH up to 128).
    localparam int CTL_IW = 7;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_DUMP   = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;
    localparam logic [1:0] ST_BADPOS = 2'd3;

    // Control broadcast from the sequencer to every cell of the chain.
    typedef struct packed {
        logic              ins;
        logic              del;
        logic              rot;
        logic [CTL_IW-1:0] pos;
        logic [CTL_IW-1:0] last;
    } t_cell_ctl;

endpackage

`default_nettype wire

FILE: design/indexed_shift_list.sv
// Top level of the indexed shift list: command sequencer and chain of cells.
//
// An ordered list of signed 32-bit words held in a row of DEPTH cells.
// A command is taken at a clock edge where start is high and busy is low.
// Insert (position 0..count) and delete (position 0..count-1) shift the cells
// at and above the position in parallel and produce one word on the result
// ports in the next cycle, so a new command may follow in every cycle.
// Dump rotates the chain toward cell 0 once per cycle and emits the head
// cell as one word per cycle; the taken start first enters the dump state,
// and the head word is then registered onto the result ports.
// A dump keeps busy high while the rotation runs through all count entries,
// so that the list ends in its original order; words past the sixteenth
// are not emitted.
// Each result word is valid for exactly one cycle with o_result_valid; the
// receiver cannot stall it. Failing commands change nothing and report
// full, empty or invalid position in o_status. Reset empties the list;
// cell contents are not cleared. The capacity register (i_cfg_we) resets
// to 16; the user must write it only while idle (the block does not check).
`default_nettype none

module indexed_shift_list
    import ils_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic        [1:0]  i_command,
    input  wire logic        [4:0]  i_position,
    input  wire logic signed [31:0] i_value,
    input  wire logic               i_cfg_we,
    input  wire logic        [4:0]  i_cfg_data,
    output logic                    o_result_valid,
    output logic             [1:0]  o_status,
    output logic signed      [31:0] o_entry_value,
    output logic             [3:0]  o_entry_index,
    output logic             [4:0]  o_used_count,
    output logic                    o_last_result
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_DUMP = 2'b10
    } t_state;

    t_state      r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [IW-1:0] r_dcnt, n_dcnt;
    logic [4:0]  r_capacity;

    logic        r_valid, n_valid;
    logic [1:0]  r_status, n_status;
    logic [31:0] r_value, n_value;
    logic [3:0]  r_index, n_index;
    logic [4:0]  r_used, n_used;
    logic        r_last, n_last;

    t_cell_ctl   ctl;
    logic [31:0] cell_q [DEPTH];

    logic        accept;
    logic [7:0]  pos_ext, cnt_ext, usable, dump_n, dcnt_ext;

    assign accept   = start && !busy;
    assign pos_ext  = 8'(i_position);
    assign cnt_ext  = 8'(r_count);
    assign dcnt_ext = 8'(r_dcnt);
    assign usable   = (8'(r_capacity) > 8'(DEPTH)) ? 8'(DEPTH) : 8'(r_capacity);
    assign dump_n   = (cnt_ext > 8'(RESULT_LIMIT)) ? 8'(RESULT_LIMIT) : cnt_ext;

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_dcnt   = r_dcnt;
        n_valid  = 1'b0;
        n_status = ST_OK;
        n_value  = '0;
        n_index  = '0;
        n_used   = 5'(r_count);
        n_last   = 1'b1;
        ctl      = '0;
        ctl.pos  = CTL_IW'(i_position);
        ctl.last = CTL_IW'(r_count - CW'(1));
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_valid = 1'b1;
                    case (i_command)
                        CMD_INSERT: begin
                            if (cnt_ext >= usable) begin
                                n_status = ST_FULL;
                            end else if (pos_ext > cnt_ext) begin
                                n_status = ST_BADPOS;
                            end else begin
                                ctl.ins = 1'b1;
                                n_count = r_count + CW'(1);
                                n_used  = 5'(r_count + CW'(1));
                            end
                        end
                        CMD_DELETE: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else if (pos_ext >= cnt_ext) begin
                                n_status = ST_BADPOS;
                            end else begin
                                ctl.del = 1'b1;
                                n_count = r_count - CW'(1);
                                n_used  = 5'(r_count - CW'(1));
                            end
                        end
                        CMD_DUMP: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_valid = 1'b0;
                                n_dcnt  = '0;
                                n_state = S_DUMP;
                            end
                        end
                        default: begin
                            n_status = ST_BADPOS;
                        end
                    endcase
                end
            end
            S_DUMP: begin
                // Emit the head word while the chain rotates one step.
                ctl.rot = 1'b1;
                n_valid = (dcnt_ext < 8'(RESULT_LIMIT));
                n_value = cell_q[0];
                n_index = 4'(r_dcnt);
                n_last  = (dcnt_ext == dump_n - 8'd1);
                if (dcnt_ext == cnt_ext - 8'd1) begin
                    n_state = S_IDLE;
                end else begin
                    n_dcnt = r_dcnt + IW'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_dcnt     <= '0;
            r_capacity <= CAP_RESET;
            r_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_dcnt  <= n_dcnt;
            r_valid <= n_valid;
            if (i_cfg_we) begin
                r_capacity <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_value  <= n_value;
        r_index  <= n_index;
        r_used   <= n_used;
        r_last   <= n_last;
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            ils_cell #(
                .IDX(g)
            ) u_cell (
                .i_clk   (i_clk),
                .i_ctl   (ctl),
                .i_load  (i_value),
                .i_left  (cell_q[(g > 0) ? g - 1 : g]),
                .i_right (cell_q[(g < DEPTH - 1) ? g + 1 : g]),
                .i_head  (cell_q[0]),
                .o_word  (cell_q[g])
            );
        end
    endgenerate

    assign busy           = (r_state == S_DUMP);
    assign o_result_valid = r_valid;
    assign o_status       = r_status;
    assign o_entry_value  = r_value;
    assign o_entry_index  = r_index;
    assign o_used_count   = r_used;
    assign o_last_result  = r_last;

    // A failed command always yields a single, final word.
    a_fail_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && (o_status != ST_OK) |-> o_last_result)
        else $error("failing status without last mark");

    // The list never holds more entries than there are cells.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        8'(r_count) <= 8'(DEPTH))
        else $error("entry count exceeds depth");

    // The dump walk never runs past the used entries.
    a_dump_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DUMP) |-> (8'(r_dcnt) < 8'(r_count)))
        else $error("dump index beyond count");

    // The count does not change while a dump is rotating the chain.
    a_dump_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DUMP) |=> $stable(r_count))
        else $error("count changed during dump");

endmodule

`default_nettype wire

FILE: design/ils_cell.sv
// One storage cell of the list: loads, shifts from a neighbor, takes the head word, or holds.
`default_nettype none

module ils_cell
    import ils_pkg::*;
#(
    parameter int IDX = 0
) (
    input  wire logic        i_clk,
    input  wire t_cell_ctl   i_ctl,
    input  wire logic [31:0] i_load,
    input  wire logic [31:0] i_left,
    input  wire logic [31:0] i_right,
    input  wire logic [31:0] i_head,
    output logic      [31:0] o_word
);

    localparam logic [CTL_IW-1:0] ME = CTL_IW'(IDX);

    logic [31:0] r_word;

    always_ff @(posedge i_clk) begin
        if (i_ctl.ins) begin
            if (ME == i_ctl.pos) begin
                r_word <= i_load;
            end else if (ME > i_ctl.pos) begin
                r_word <= i_left;
            end
        end else if (i_ctl.del) begin
            if (ME >= i_ctl.pos) begin
                r_word <= i_right;
            end
        end else if (i_ctl.rot) begin
            // The cell holding the last entry takes the word leaving the head.
            if (ME == i_ctl.last) begin
                r_word <= i_head;
            end else begin
                r_word <= i_right;
            end
        end
    end

    assign o_word = r_word;

endmodule

`default_nettype wire

FILE: test/tb.sv
// Testbench for the indexed shift list: directed and random commands checked against a predictor.
`timescale 1ns / 100ps

module tb;
    import ils_pkg::*;

    // Command code 3 has no meaning; the block must answer it with an invalid position.
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int IDLE_LIMIT = 400;

    typedef struct {
        logic [1:0]         cmd;
        logic [4:0]         pos;
        logic signed [31:0] val;
        int                 gap;
    } list_cmd_t;

    typedef struct {
        logic [1:0]         status;
        logic signed [31:0] value;
        logic [3:0]         index;
        logic [4:0]         used;
        logic               last;
    } list_word_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [1:0]         i_command = CMD_INSERT;
    logic [4:0]         i_position = '0;
    logic signed [31:0] i_value = '0;
    logic               i_cfg_we = 1'b0;
    logic [4:0]         i_cfg_data = '0;
    logic               o_result_valid;
    logic [1:0]         o_status;
    logic signed [31:0] o_entry_value;
    logic [3:0]         o_entry_index;
    logic [4:0]         o_used_count;
    logic               o_last_result;

    // Shadow copy of the list and its capacity register.
    logic signed [31:0] list_mem [DEPTH_DEFAULT];
    logic [4:0]         list_count = '0;
    logic [4:0]         list_cap = CAP_RESET;

    list_word_t due_words[$];
    list_cmd_t  cmd_q[$];
    list_cmd_t  nxt;
    list_word_t seen_word;
    bit         have_nxt = 1'b0;
    int         wait_left = 0;
    bit         quiet = 1'b0;
    int         quiet_left = 0;
    int         idle_cycles = 0;
    int         n_items = 0;
    int         n_words = 0;
    int         n_dumps = 0;
    int         n_caps = 0;
    int         n_err = 0;

    indexed_shift_list #(.DEPTH(DEPTH_DEFAULT)) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_command      (i_command),
        .i_position     (i_position),
        .i_value        (i_value),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .o_result_valid (o_result_valid),
        .o_status       (o_status),
        .o_entry_value  (o_entry_value),
        .o_entry_index  (o_entry_index),
        .o_used_count   (o_used_count),
        .o_last_result  (o_last_result)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    task automatic due_word(input logic [1:0] st, input logic signed [31:0] v,
                            input logic [3:0] idx, input logic last);
        list_word_t w;
        w.status = st;
        w.value  = v;
        w.index  = idx;
        w.used   = list_count;
        w.last   = last;
        due_words.push_back(w);
    endtask

    task automatic list_apply(input logic [1:0] cmd, input logic [4:0] pos,
                              input logic signed [31:0] val);
        int room;
        int n;
        int i;
        room = (list_cap > DEPTH_DEFAULT) ? DEPTH_DEFAULT : int'(list_cap);
        case (cmd)
            CMD_INSERT: begin
                // Fullness is judged before the position.
                if (list_count >= room) begin
                    due_word(ST_FULL, '0, '0, 1'b1);
                end else if (pos > list_count) begin
                    due_word(ST_BADPOS, '0, '0, 1'b1);
                end else begin
                    for (i = list_count; i > pos; i--) list_mem[i] = list_mem[i - 1];
                    list_mem[pos] = val;
                    list_count++;
                    due_word(ST_OK, '0, '0, 1'b1);
                end
            end
            CMD_DELETE: begin
                if (list_count == 0) begin
                    due_word(ST_EMPTY, '0, '0, 1'b1);
                end else if (pos >= list_count) begin
                    due_word(ST_BADPOS, '0, '0, 1'b1);
                end else begin
                    for (i = pos; i + 1 < list_count; i++) list_mem[i] = list_mem[i + 1];
                    list_count--;
                    due_word(ST_OK, '0, '0, 1'b1);
                end
            end
            CMD_DUMP: begin
                n_dumps++;
                if (list_count == 0) begin
                    due_word(ST_EMPTY, '0, '0, 1'b1);
                end else begin
                    n = (list_count > RESULT_LIMIT) ? RESULT_LIMIT : int'(list_count);
                    for (i = 0; i < n; i++) due_word(ST_OK, list_mem[i], i[3:0], i == n - 1);
                end
            end
            default: begin
                due_word(ST_BADPOS, '0, '0, 1'b1);
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            n_err++;
            $display("%0t: %s expected %h got %h", $time, name, want, got);
        end
    endtask

    // Driver: holds each command word on the bus until the block takes it.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                list_apply(i_command, i_position, i_value);
                n_items++;
            end
            if (!start || !busy) begin
                if (!have_nxt && cmd_q.size() > 0) begin
                    nxt = cmd_q.pop_front();
                    have_nxt = 1'b1;
                    wait_left = nxt.gap;
                end
                if (have_nxt && wait_left == 0) begin
                    start <= 1'b1;
                    i_command <= nxt.cmd;
                    i_position <= nxt.pos;
                    i_value <= nxt.val;
                    have_nxt = 1'b0;
                end else begin
                    start <= 1'b0;
                    if (have_nxt) wait_left--;
                end
            end
        end
    end

    // Monitor: every result word is compared with the oldest one due.
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid === 1'b1) begin
            n_words++;
            if (due_words.size() == 0) begin
                n_err++;
                $display("%0t: word not expected, status %0d value %h index %0d", $time,
                         o_status, o_entry_value, o_entry_index);
            end else begin
                seen_word = due_words.pop_front();
                check_field("status", seen_word.status, o_status);
                check_field("entry_value", seen_word.value, o_entry_value);
                check_field("entry_index", seen_word.index, o_entry_index);
                check_field("used_count", seen_word.used, o_used_count);
                check_field("last_result", seen_word.last, o_last_result);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_result_valid === 1'b1 || i_cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no word moved for %0d cycles, %0d words still due", $time,
                     idle_cycles, due_words.size());
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic queue_cmd(input logic [1:0] cmd, input logic [4:0] pos,
                             input logic signed [31:0] val);
        list_cmd_t c;
        // Mix stretches of back-to-back commands with stretches of random gaps.
        if (quiet_left == 0) begin
            quiet = ($urandom_range(0, 2) == 0);
            quiet_left = $urandom_range(8, 24);
        end
        quiet_left--;
        c.cmd = cmd;
        c.pos = pos;
        c.val = val;
        c.gap = quiet ? 0 : $urandom_range(0, 14);
        cmd_q.push_back(c);
    endtask

    task automatic random_phase(input int n, input int grow_pct);
        int k;
        int r;
        logic [1:0] cmd;
        logic [4:0] pos;
        for (k = 0; k < n; k++) begin
            @(negedge i_clk);
            while (cmd_q.size() != 0) @(negedge i_clk);
            r = $urandom_range(0, 99);
            if (r < 3) cmd = CMD_UNUSED;
            else if (r < 17) cmd = CMD_DUMP;
            else if (r < 17 + (83 * grow_pct) / 100) cmd = CMD_INSERT;
            else cmd = CMD_DELETE;
            // Mostly positions inside the list, now and then any 5-bit value.
            if ($urandom_range(0, 9) == 0) pos = 5'($urandom_range(0, 31));
            else if (cmd == CMD_DELETE) pos = (list_count == 0) ? 5'd0 :
                                              5'($urandom_range(0, list_count - 1));
            else pos = 5'($urandom_range(0, list_count));
            queue_cmd(cmd, pos, $urandom());
        end
    endtask

    task automatic wait_quiet;
        @(negedge i_clk);
        while (cmd_q.size() != 0 || have_nxt || start || busy !== 1'b0 ||
               due_words.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_capacity(input logic [4:0] cap);
        wait_quiet();
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= cap;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        list_cap = cap;
        n_caps++;
    endtask

    initial begin
        // Directed commands at the reset capacity.
        queue_cmd(CMD_DUMP, 5'd0, 32'sd0);
        queue_cmd(CMD_DELETE, 5'd0, 32'sd0);
        queue_cmd(CMD_DELETE, 5'd31, 32'sd0);
        queue_cmd(CMD_INSERT, 5'd1, 32'sd7);
        queue_cmd(CMD_INSERT, 5'd0, 32'h8000_0000);
        queue_cmd(CMD_INSERT, 5'd1, 32'h7fff_ffff);
        queue_cmd(CMD_INSERT, 5'd0, -32'sd1);
        queue_cmd(CMD_INSERT, 5'd1, 32'sd0);
        queue_cmd(CMD_INSERT, 5'd31, 32'sd5);
        queue_cmd(CMD_INSERT, 5'd5, 32'sd9);
        queue_cmd(CMD_UNUSED, 5'd31, 32'hffff_ffff);
        queue_cmd(CMD_DUMP, 5'd31, 32'hffff_ffff);
        queue_cmd(CMD_DELETE, 5'd4, 32'sd0);
        queue_cmd(CMD_DELETE, 5'd3, 32'sd0);
        queue_cmd(CMD_DELETE, 5'd0, 32'sd0);
        queue_cmd(CMD_DUMP, 5'd0, 32'sd0);
        queue_cmd(CMD_DELETE, 5'd31, 32'sd0);
        queue_cmd(CMD_INSERT, 5'd2, 32'h5a5a_a5a5);
        queue_cmd(CMD_DUMP, 5'd0, 32'sd0);

        set_capacity(5'd16);
        random_phase(30, 85);
        set_capacity(5'd3);
        random_phase(15, 40);
        set_capacity(5'd0);
        random_phase(10, 50);
        set_capacity(5'd31);
        random_phase(25, 80);
        set_capacity(5'd1);
        random_phase(15, 50);
        set_capacity(5'd17);
        random_phase(25, 55);
        set_capacity(5'($urandom_range(1, 16)));
        random_phase(20, 50);
        set_capacity(5'd16);
        random_phase(20, 20);
        set_capacity(5'($urandom_range(0, 31)));
        random_phase(20, 50);
        wait_quiet();

        $display("Ran %0d commands, %0d of them dumps, across %0d capacity writes.",
                 n_items, n_dumps, n_caps);
        $display("Checked %0d result words against the predicted list.", n_words);
        if (n_err == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

FILE: sim.f
design/ils_pkg.sv
design/ils_cell.sv
design/indexed_shift_list.sv
test/tb.sv
